// ----- design/deer_pkg.sv -----
`timescale 1ns / 1ps
package deer_pkg;
  localparam int MAX_SCORES_DEF  = 1024;
  localparam int SWEEP_STEPS_DEF = 1000;
  localparam int SCORE_BITS_DEF  = 16;

  localparam int ID_W   = 16;
  localparam int IN_W   = 16;
  localparam int RATE_W = 17;
  localparam int TOT_W  = 11;
  localparam int STAT_W = 2;
  localparam int FRAC_W = 16;

  localparam logic [RATE_W-1:0] TARGET_RST = 17'd655;
  localparam logic [RATE_W-1:0] ONE_Q16    = 17'h10000;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_DROPPED = 2'd2
  } status_e;
endpackage

// ----- design/deer_ram.sv -----
`timescale 1ns / 1ps
module deer_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ----- design/deer_div.sv -----
`timescale 1ns / 1ps
module deer_div #(
  parameter int NW = 27,
  parameter int DW = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);
  localparam int CNTW = $clog2(NW + 1);

  logic            busy_q, busy_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [NW-1:0]   num_q, num_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   den_q, den_d;
  logic [DW:0]     trial;
  logic            ge;

  assign trial  = {rem_q, num_q[NW-1]};
  assign ge     = trial >= {1'b0, den_q};
  assign done_o = busy_q && (cnt_q == '0);
  assign quo_o  = num_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNTW'(NW);
      num_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
        rem_d = ge ? DW'(trial - {1'b0, den_q}) : DW'(trial);
        num_d = {num_q[NW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end
endmodule

// ----- design/deer_front.sv -----
`timescale 1ns / 1ps
module deer_front import deer_pkg::*; #(
  parameter int SCORE_BITS = SCORE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [ID_W-1:0]       first_subject_i,
  input  logic [ID_W-1:0]       second_subject_i,
  input  logic [IN_W-1:0]       distance_score_i,
  input  logic                  final_score_i,
  output logic                  q_empty_o,
  input  logic                  q_pop_i,
  output logic [SCORE_BITS-1:0] q_score_o,
  output logic                  q_gen_o,
  output logic                  q_last_o
);
  logic [SCORE_BITS-1:0] score_q [2];
  logic [1:0]            gen_q, last_q;
  logic                  wp_q, rp_q;
  logic [1:0]            cnt_q;
  logic                  do_push, do_pop;

  assign full      = cnt_q == 2'd2;
  assign q_empty_o = cnt_q == 2'd0;
  assign do_push   = push && !full;
  assign do_pop    = q_pop_i && !q_empty_o;
  assign q_score_o = score_q[rp_q];
  assign q_gen_o   = gen_q[rp_q];
  assign q_last_o  = last_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      score_q[wp_q] <= SCORE_BITS'(distance_score_i);
      gen_q[wp_q]   <= first_subject_i == second_subject_i;
      last_q[wp_q]  <= final_score_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wp_q <= !wp_q;
      end
      if (do_pop) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule

// ----- design/deer_back.sv -----
`timescale 1ns / 1ps
module deer_back import deer_pkg::*; #(
  parameter int MAX_SCORES  = MAX_SCORES_DEF,
  parameter int SWEEP_STEPS = SWEEP_STEPS_DEF,
  parameter int SCORE_BITS  = SCORE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  output logic                  q_pop_o,
  input  logic [SCORE_BITS-1:0] q_score_i,
  input  logic                  q_gen_i,
  input  logic                  q_last_i,
  input  logic [RATE_W-1:0]     target_i,
  input  logic                  pop,
  output logic                  empty,
  output logic [RATE_W-1:0]     equal_error_rate_o,
  output logic [IN_W-1:0]       eer_threshold_o,
  output logic [RATE_W-1:0]     fnmr_at_target_o,
  output logic [TOT_W-1:0]      genuine_total_o,
  output logic [TOT_W-1:0]      impostor_total_o,
  output logic [STAT_W-1:0]     status_code_o
);
  localparam int SB   = SCORE_BITS;
  localparam int CW   = $clog2(MAX_SCORES + 1);
  localparam int AW   = $clog2(MAX_SCORES);
  localparam int STW  = $clog2(SWEEP_STEPS + 1);
  localparam int NUMW = (CW + FRAC_W > SB) ? CW + FRAC_W : SB;
  localparam int DENW = (CW > STW) ? CW : STW;
  localparam int RSH  = SB + $clog2(SWEEP_STEPS);
  localparam int MW   = SB + 2;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << RSH) + 64'(SWEEP_STEPS) - 64'd1) / 64'(SWEEP_STEPS));

  typedef enum logic [7:0] {
    ST_LOAD = 8'b0000_0001,
    ST_CHK  = 8'b0000_0010,
    ST_SPAN = 8'b0000_0100,
    ST_SCAN = 8'b0000_1000,
    ST_FNMR = 8'b0001_0000,
    ST_FMR  = 8'b0010_0000,
    ST_UPD  = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] gen_q, gen_d, imp_q, imp_d, held;
  logic [SB-1:0] lo_q, lo_d, hi_q, hi_d;
  logic          ovf_q, ovf_d;
  logic [SB-1:0] thr_q, thr_d, qs_q, qs_d;
  logic [STW-1:0] rs_q, rs_d, step_q, step_d;
  logic [STW:0]  frac_q, frac_d, frac_sum;
  logic          wrap;
  logic [CW-1:0] k_q, k_d, above_q, above_d, below_q, below_d;
  logic          rd_vld_q, rd_vld_d;
  logic [RATE_W-1:0] fnmr_q, fnmr_d, fmr_q, fmr_d;
  logic [RATE_W-1:0] bd_q, bd_d, bt_q, bt_d, eer_q, eer_d, ftg_q, ftg_d;
  logic [SB-1:0] ethr_q, ethr_d;
  status_e       stat_q, stat_d;
  logic [RATE_W-1:0] d_cur, dt_cur;
  logic [RATE_W:0]   rate_sum;
  logic          out_vld_q, out_vld_d, out_load;
  logic [SB-1:0]     span;
  logic [SB+MW-1:0]  span_prod;
  logic [SB+STW-1:0] span_back;

  logic          ram_we;
  logic [SB:0]   ram_rdata;
  logic [AW-1:0] ram_raddr;
  logic          div_start, div_done;
  logic [NUMW-1:0] div_num, div_quo;
  logic [DENW-1:0] div_den;
  logic          is_full, take;

  assign held     = gen_q + imp_q;
  assign is_full  = held == CW'(MAX_SCORES);
  assign take     = (state_q == ST_LOAD) && !q_empty_i;
  assign q_pop_o  = take;
  assign ram_we   = take && !is_full;
  assign ram_raddr = k_q[AW-1:0];
  assign empty    = !out_vld_q;

  // span split by reciprocal multiplication, remainder by back multiplication
  assign span      = hi_q - lo_q;
  assign span_prod = {{MW{1'b0}}, span} * {{SB{1'b0}}, RECIP};
  assign span_back = {{STW{1'b0}}, qs_q} * (SB+STW)'(SWEEP_STEPS);

  assign frac_sum = frac_q + (STW+1)'(rs_q);
  assign wrap     = frac_sum >= (STW+1)'(SWEEP_STEPS);
  assign d_cur    = (fnmr_q > fmr_q) ? fnmr_q - fmr_q : fmr_q - fnmr_q;
  assign dt_cur   = (fmr_q > target_i) ? fmr_q - target_i : target_i - fmr_q;
  assign rate_sum = {1'b0, fnmr_q} + {1'b0, fmr_q};
  assign out_load = (state_q == ST_OUT) && !out_vld_q;

  deer_ram #(.WIDTH(SB + 1), .DEPTH(MAX_SCORES)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (held[AW-1:0]),
    .wdata_i ({q_gen_i, q_score_i}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  deer_div #(.NW(NUMW), .DW(DENW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    state_d  = state_q;
    gen_d    = gen_q;
    imp_d    = imp_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    ovf_d    = ovf_q;
    thr_d    = thr_q;
    qs_d     = qs_q;
    rs_d     = rs_q;
    step_d   = step_q;
    frac_d   = frac_q;
    k_d      = k_q;
    above_d  = above_q;
    below_d  = below_q;
    rd_vld_d = 1'b0;
    fnmr_d   = fnmr_q;
    fmr_d    = fmr_q;
    bd_d     = bd_q;
    bt_d     = bt_q;
    eer_d    = eer_q;
    ftg_d    = ftg_q;
    ethr_d   = ethr_q;
    stat_d   = stat_q;
    out_vld_d = out_vld_q && !pop;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_q)
      ST_LOAD: begin
        if (take) begin
          if (is_full) begin
            ovf_d = 1'b1;
          end else begin
            if (q_gen_i) begin
              gen_d = gen_q + 1'b1;
            end else begin
              imp_d = imp_q + 1'b1;
            end
            if (q_score_i < lo_q) begin
              lo_d = q_score_i;
            end
            if (q_score_i > hi_q) begin
              hi_d = q_score_i;
            end
          end
          if (q_last_i) begin
            state_d = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        if (gen_q == '0 || imp_q == '0) begin
          stat_d  = STAT_EMPTY;
          eer_d   = '0;
          ethr_d  = '0;
          ftg_d   = '0;
          state_d = ST_OUT;
        end else begin
          stat_d  = ovf_q ? STAT_DROPPED : STAT_OK;
          qs_d    = SB'(span_prod >> RSH);
          state_d = ST_SPAN;
        end
      end
      ST_SPAN: begin
        rs_d    = STW'({{STW{1'b0}}, span} - span_back);
        thr_d   = lo_q;
        frac_d  = '0;
        step_d  = '0;
        k_d     = '0;
        above_d = '0;
        below_d = '0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (k_q < held) begin
          k_d      = k_q + 1'b1;
          rd_vld_d = 1'b1;
        end
        if (rd_vld_q) begin
          if (ram_rdata[SB]) begin
            if (ram_rdata[SB-1:0] > thr_q) begin
              above_d = above_q + 1'b1;
            end
          end else if (ram_rdata[SB-1:0] < thr_q) begin
            below_d = below_q + 1'b1;
          end
        end
        div_num = NUMW'({above_q, {FRAC_W{1'b0}}});
        div_den = DENW'(gen_q);
        if (k_q == held && !rd_vld_q) begin
          div_start = 1'b1;
          state_d   = ST_FNMR;
        end
      end
      ST_FNMR: begin
        div_num = NUMW'({below_q, {FRAC_W{1'b0}}});
        div_den = DENW'(imp_q);
        if (div_done) begin
          fnmr_d    = RATE_W'(div_quo);
          div_start = 1'b1;
          state_d   = ST_FMR;
        end
      end
      ST_FMR: begin
        if (div_done) begin
          fmr_d   = RATE_W'(div_quo);
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (step_q == '0 || d_cur < bd_q) begin
          bd_d   = d_cur;
          eer_d  = rate_sum[RATE_W:1];
          ethr_d = thr_q;
        end
        if (step_q == '0 || dt_cur < bt_q) begin
          bt_d  = dt_cur;
          ftg_d = fnmr_q;
        end
        if (step_q == STW'(SWEEP_STEPS)) begin
          state_d = ST_OUT;
        end else begin
          step_d  = step_q + 1'b1;
          frac_d  = wrap ? frac_sum - (STW+1)'(SWEEP_STEPS) : frac_sum;
          thr_d   = thr_q + qs_q + SB'(wrap);
          k_d     = '0;
          above_d = '0;
          below_d = '0;
          state_d = ST_SCAN;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_vld_d = 1'b1;
          gen_d     = '0;
          imp_d     = '0;
          lo_d      = '1;
          hi_d      = '0;
          ovf_d     = 1'b0;
          state_d   = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      gen_q     <= '0;
      imp_q     <= '0;
      lo_q      <= '1;
      hi_q      <= '0;
      ovf_q     <= 1'b0;
      k_q       <= '0;
      rd_vld_q  <= 1'b0;
      step_q    <= '0;
      frac_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      gen_q     <= gen_d;
      imp_q     <= imp_d;
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      ovf_q     <= ovf_d;
      k_q       <= k_d;
      rd_vld_q  <= rd_vld_d;
      step_q    <= step_d;
      frac_q    <= frac_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    thr_q   <= thr_d;
    qs_q    <= qs_d;
    rs_q    <= rs_d;
    above_q <= above_d;
    below_q <= below_d;
    fnmr_q  <= fnmr_d;
    fmr_q   <= fmr_d;
    bd_q    <= bd_d;
    bt_q    <= bt_d;
    eer_q   <= eer_d;
    ftg_q   <= ftg_d;
    ethr_q  <= ethr_d;
    stat_q  <= stat_d;
    if (out_load) begin
      equal_error_rate_o <= eer_q;
      eer_threshold_o    <= IN_W'(ethr_q);
      fnmr_at_target_o   <= ftg_q;
      genuine_total_o    <= TOT_W'(gen_q);
      impostor_total_o   <= TOT_W'(imp_q);
      status_code_o      <= stat_q;
    end
  end

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((CW+1)'(gen_q) + (CW+1)'(imp_q)) <= (CW+1)'(MAX_SCORES))
    else $error("score count beyond store depth");

  a_rates_q16: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD |-> (fnmr_q <= ONE_Q16 && fmr_q <= ONE_Q16))
    else $error("rate above one");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> frac_q < (STW+1)'(SWEEP_STEPS))
    else $error("threshold remainder out of range");

  a_out_from_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q) == ST_OUT)
    else $error("result loaded outside output state");
endmodule

// ----- design/det_curve_equal_error_rate.sv -----
`timescale 1ns / 1ps
// channel  | handshake          | payload
// input    | push / full        | first_subject, second_subject, distance_score, final_score
// result   | empty / pop        | eer, threshold, fnmr_at_target, totals, status_code
// config   | cfg_we_i           | cfg_wdata_i (target false match rate)
// a non-final item is stored; a two-entry queue buffers input
// a final item runs a sweep of SWEEP_STEPS+1 thresholds, each scanning all held
// scores one per cycle from the store memory plus two serial divisions
// after a reciprocal span split, when both genuine and impostor scores are held
// reset clears counts and extremes; the store needs no clearing
// input stalls when the queue is full; a result waits in its register for pop
module det_curve_equal_error_rate import deer_pkg::*; #(
  parameter int MAX_SCORES  = MAX_SCORES_DEF,
  parameter int SWEEP_STEPS = SWEEP_STEPS_DEF,
  parameter int SCORE_BITS  = SCORE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [ID_W-1:0]   first_subject_i,
  input  logic [ID_W-1:0]   second_subject_i,
  input  logic [IN_W-1:0]   distance_score_i,
  input  logic              final_score_i,
  input  logic              pop,
  output logic              empty,
  output logic [RATE_W-1:0] equal_error_rate_o,
  output logic [IN_W-1:0]   eer_threshold_o,
  output logic [RATE_W-1:0] fnmr_at_target_o,
  output logic [TOT_W-1:0]  genuine_total_o,
  output logic [TOT_W-1:0]  impostor_total_o,
  output logic [STAT_W-1:0] status_code_o,
  input  logic              cfg_we_i,
  input  logic [RATE_W-1:0] cfg_wdata_i
);
  logic [RATE_W-1:0]     target_q;
  logic                  q_empty, q_pop, q_gen, q_last;
  logic [SCORE_BITS-1:0] q_score;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RST;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  deer_front #(.SCORE_BITS(SCORE_BITS)) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .first_subject_i  (first_subject_i),
    .second_subject_i (second_subject_i),
    .distance_score_i (distance_score_i),
    .final_score_i    (final_score_i),
    .q_empty_o        (q_empty),
    .q_pop_i          (q_pop),
    .q_score_o        (q_score),
    .q_gen_o          (q_gen),
    .q_last_o         (q_last)
  );

  deer_back #(
    .MAX_SCORES  (MAX_SCORES),
    .SWEEP_STEPS (SWEEP_STEPS),
    .SCORE_BITS  (SCORE_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_empty_i          (q_empty),
    .q_pop_o            (q_pop),
    .q_score_i          (q_score),
    .q_gen_i            (q_gen),
    .q_last_i           (q_last),
    .target_i           (target_q),
    .pop                (pop),
    .empty              (empty),
    .equal_error_rate_o (equal_error_rate_o),
    .eer_threshold_o    (eer_threshold_o),
    .fnmr_at_target_o   (fnmr_at_target_o),
    .genuine_total_o    (genuine_total_o),
    .impostor_total_o   (impostor_total_o),
    .status_code_o      (status_code_o)
  );
endmodule

// ----- bench/det_curve_equal_error_rate_tb.sv -----
`timescale 1ns / 1ps
module det_curve_equal_error_rate_tb;
  import deer_pkg::*;

  localparam int STORE_DEPTH  = MAX_SCORES_DEF;
  localparam int STEPS        = SWEEP_STEPS_DEF;
  localparam int RANDOM_ITEMS = 560;
  localparam int IDLE_LIMIT   = 3000000;
  localparam int HOLD_CYCLES  = 3000;
  localparam int SETTLE       = 40;

  typedef struct packed {
    logic [RATE_W-1:0] eer;
    logic [IN_W-1:0]   thr;
    logic [RATE_W-1:0] fnmr;
    logic [TOT_W-1:0]  gen;
    logic [TOT_W-1:0]  imp;
    status_e           st;
  } eer_result_t;

  typedef struct packed {
    logic [ID_W-1:0] a;
    logic [ID_W-1:0] b;
    logic [IN_W-1:0] sc;
    logic            fin;
    logic            typed;
    eer_result_t     res;
  } score_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [ID_W-1:0] first_subject_i = '0;
  logic [ID_W-1:0] second_subject_i = '0;
  logic [IN_W-1:0] distance_score_i = '0;
  logic final_score_i = 1'b0;
  logic pop = 1'b0;
  logic empty;
  logic [RATE_W-1:0] equal_error_rate_o;
  logic [IN_W-1:0] eer_threshold_o;
  logic [RATE_W-1:0] fnmr_at_target_o;
  logic [TOT_W-1:0] genuine_total_o;
  logic [TOT_W-1:0] impostor_total_o;
  logic [STAT_W-1:0] status_code_o;
  logic cfg_we_i = 1'b0;
  logic [RATE_W-1:0] cfg_wdata_i = '0;

  det_curve_equal_error_rate dut (
    .clk_i, .rst_ni, .push, .full,
    .first_subject_i, .second_subject_i, .distance_score_i, .final_score_i,
    .pop, .empty,
    .equal_error_rate_o, .eer_threshold_o, .fnmr_at_target_o,
    .genuine_total_o, .impostor_total_o, .status_code_o,
    .cfg_we_i, .cfg_wdata_i
  );

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [SCORE_BITS_DEF:0] pm_store [STORE_DEPTH];
  int unsigned pm_gen, pm_imp;
  logic [IN_W-1:0] pm_low, pm_high;
  bit pm_ovf;
  logic [RATE_W-1:0] pm_target = TARGET_RST;

  eer_result_t eer_q[$];
  int fail_cnt = 0;
  int mism_cnt = 0;
  bit hold_req = 0;
  bit accepted_any = 0;
  int burst_left = 0;

  function automatic void clear_batch();
    pm_gen = 0;
    pm_imp = 0;
    pm_low = '1;
    pm_high = '0;
    pm_ovf = 0;
  endfunction

  function automatic void sweep_rates(output eer_result_t r);
    longint unsigned span, t, above, below, fnmr, fmr, d, dt, best_d, best_t;
    int unsigned held;
    span = pm_high - pm_low;
    held = pm_gen + pm_imp;
    best_d = 0;
    best_t = 0;
    r = '0;
    for (int i = 0; i <= STEPS; i++) begin
      t = pm_low + (longint'(i) * span) / STEPS;
      above = 0;
      below = 0;
      for (int k = 0; k < held; k++) begin
        if (pm_store[k][SCORE_BITS_DEF]) begin
          if (pm_store[k][IN_W-1:0] > t) above++;
        end else begin
          if (pm_store[k][IN_W-1:0] < t) below++;
        end
      end
      fnmr = (above * 65536) / pm_gen;
      fmr = (below * 65536) / pm_imp;
      d = (fnmr > fmr) ? fnmr - fmr : fmr - fnmr;
      dt = (fmr > pm_target) ? fmr - pm_target : pm_target - fmr;
      if (i == 0 || d < best_d) begin
        best_d = d;
        r.eer = RATE_W'((fnmr + fmr) >> 1);
        r.thr = IN_W'(t);
      end
      if (i == 0 || dt < best_t) begin
        best_t = dt;
        r.fnmr = RATE_W'(fnmr);
      end
    end
  endfunction

  function automatic bit score_batch(input logic [ID_W-1:0] a, input logic [ID_W-1:0] b,
                                     input logic [IN_W-1:0] sc, input logic fin,
                                     output eer_result_t r);
    int unsigned held;
    held = pm_gen + pm_imp;
    r = '0;
    if (held < STORE_DEPTH) begin
      pm_store[held] = {a == b, sc};
      if (a == b) pm_gen++; else pm_imp++;
      if (sc < pm_low) pm_low = sc;
      if (sc > pm_high) pm_high = sc;
    end else begin
      pm_ovf = 1;
    end
    if (!fin) return 0;
    if (pm_gen == 0 || pm_imp == 0) begin
      r.st = STAT_EMPTY;
    end else begin
      sweep_rates(r);
      r.st = pm_ovf ? STAT_DROPPED : STAT_OK;
    end
    r.gen = TOT_W'(pm_gen);
    r.imp = TOT_W'(pm_imp);
    clear_batch();
    return 1;
  endfunction

  task automatic send_score(input score_row_t row);
    eer_result_t r;
    bit got;
    if (burst_left == 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0) @(negedge clk_i);
      burst_left = $urandom_range(1, 30);
    end else begin
      @(negedge clk_i);
    end
    push <= 1'b1;
    first_subject_i <= row.a;
    second_subject_i <= row.b;
    distance_score_i <= row.sc;
    final_score_i <= row.fin;
    do @(posedge clk_i); while (full);
    burst_left--;
    got = score_batch(row.a, row.b, row.sc, row.fin, r);
    if (got) eer_q.push_back(row.typed ? row.res : r);
  endtask

  task automatic write_target(input logic [RATE_W-1:0] v);
    @(negedge clk_i);
    push <= 1'b0;
    burst_left = 0;
    wait (eer_q.size() == 0);
    repeat (SETTLE) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    pm_target = v;
  endtask

  function automatic score_row_t make_row(input bit genuine, input logic [IN_W-1:0] sc,
                                          input logic fin);
    score_row_t row;
    row = '0;
    row.a = 16'($urandom_range(0, 65535));
    row.b = genuine ? row.a : row.a ^ 16'($urandom_range(1, 65535));
    row.sc = sc;
    row.fin = fin;
    return row;
  endfunction

  function automatic logic [IN_W-1:0] rand_score(input int mode);
    case (mode)
      0: return IN_W'($urandom_range(0, 65535));
      1: return IN_W'($urandom_range(1000, 1015));
      default: return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
    endcase
  endfunction

  // receiver
  always @(negedge clk_i) begin
    if (hold_req) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 7) < 5);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && push && !full) accepted_any <= 1'b1;
    if (rst_ni && pop && !empty) begin
      accepted_any <= 1'b1;
      if (eer_q.size() == 0) begin
        fail_cnt++;
        if (mism_cnt < 10) $display("unexpected result item");
        mism_cnt++;
      end else begin
        eer_result_t e, g;
        e = eer_q.pop_front();
        g.eer = equal_error_rate_o;
        g.thr = eer_threshold_o;
        g.fnmr = fnmr_at_target_o;
        g.gen = genuine_total_o;
        g.imp = impostor_total_o;
        g.st = status_e'(status_code_o);
        if (g !== e) begin
          fail_cnt++;
          if (mism_cnt < 10)
            $display("mismatch exp eer=%0d thr=%0d fnmr=%0d gen=%0d imp=%0d st=%0d | act eer=%0d thr=%0d fnmr=%0d gen=%0d imp=%0d st=%0d",
                     e.eer, e.thr, e.fnmr, e.gen, e.imp, e.st,
                     g.eer, g.thr, g.fnmr, g.gen, g.imp, g.st);
          mism_cnt++;
        end
      end
    end
  end

  // watchdog
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      #0.1;
      if (accepted_any) idle = 0; else idle++;
      accepted_any = 0;
      if (idle >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // receiver long hold-off
  initial begin
    wait (hold_req);
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_req = 0;
  end

  score_row_t dir_tab [10];

  initial begin
    int sent, mixed_left, n, mode;
    bit gen_only;
    score_row_t row;
    clear_batch();
    dir_tab[0] = '{16'd5, 16'd5, 16'd100, 1'b1, 1'b1,
                   '{17'd0, 16'd0, 17'd0, 11'd1, 11'd0, STAT_EMPTY}};
    dir_tab[1] = '{16'd1, 16'd2, 16'd0, 1'b1, 1'b1,
                   '{17'd0, 16'd0, 17'd0, 11'd0, 11'd1, STAT_EMPTY}};
    dir_tab[2] = '{16'd0, 16'd0, 16'd0, 1'b0, 1'b0, '0};
    dir_tab[3] = '{16'hffff, 16'hffff, 16'hffff, 1'b0, 1'b0, '0};
    dir_tab[4] = '{16'd0, 16'hffff, 16'd0, 1'b0, 1'b0, '0};
    dir_tab[5] = '{16'hffff, 16'd0, 16'hffff, 1'b1, 1'b0, '0};
    dir_tab[6] = '{16'd7, 16'd7, 16'd300, 1'b0, 1'b0, '0};
    dir_tab[7] = '{16'd7, 16'd8, 16'd300, 1'b1, 1'b0, '0};
    dir_tab[8] = '{16'd1, 16'd1, 16'hffff, 1'b0, 1'b0, '0};
    dir_tab[9] = '{16'd2, 16'd3, 16'd0, 1'b1, 1'b0, '0};

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < 10; i++) send_score(dir_tab[i]);

    // target extremes
    write_target('0);
    send_score(make_row(1, 16'd10, 0));
    send_score(make_row(0, 16'd20, 0));
    send_score(make_row(1, 16'd30, 1));
    write_target(ONE_Q16);
    send_score(make_row(0, 16'd10, 0));
    send_score(make_row(1, 16'd20, 0));
    send_score(make_row(0, 16'd30, 1));

    // fill up behind a stalled receiver
    write_target(TARGET_RST);
    hold_req = 1;
    for (int i = 0; i < 10; i++) send_score(make_row(i[0], rand_score(0), 1));

    // random batches
    sent = 0;
    mixed_left = 10;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0: write_target('0);
        1: write_target(ONE_Q16);
        default: write_target(RATE_W'($urandom_range(0, 65536)));
      endcase
      mode = $urandom_range(0, 2);
      if (mixed_left > 0 && $urandom_range(0, 2) == 0) begin
        mixed_left--;
        n = $urandom_range(2, 40);
        for (int i = 0; i < n; i++)
          send_score(make_row(1'($urandom_range(0, 1)), rand_score(mode), i == n - 1));
      end else begin
        n = $urandom_range(1, 20);
        gen_only = 1'($urandom_range(0, 1));
        for (int i = 0; i < n; i++) begin
          row = make_row(gen_only, rand_score(mode), i == n - 1);
          if ($urandom_range(0, 9) == 0) row.fin = 1;
          send_score(row);
        end
      end
      sent += n;
    end

    @(negedge clk_i);
    push <= 1'b0;
    wait (eer_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
